// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the decoder RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: hw/rtl/ctc_pkg.sv
// Shared types and fixed constants of the greedy CTC decoder.
// Depends on nothing; used by every module of the decoder.
package ctc_pkg;

  // Field widths fixed by the interface.
  localparam int DICT_W      = 13;
  localparam int SCORE_W     = 16;
  localparam int SUM_W       = 26;
  localparam int COUNT_OUT_W = 11;

  // Dictionary size after reset, and the largest class that can be a dictionary entry.
  localparam logic [DICT_W-1:0] DICT_RESET = 13'h1FFF;
  localparam int CLASS_MAX = 8191;

  // Timestep queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;

  // Divider step counter: one quotient bit per step over the whole sum.
  localparam int DIV_CNT_W = 5;

  // One finished timestep, as handed from the front to the back.
  typedef struct packed {
    logic              big;        // winning class lies beyond any dictionary entry
    logic [DICT_W-1:0] cls;        // low bits of the winning class
    logic [SCORE_W-1:0] score;     // winning score
    logic              last_step;  // timestep ends the sequence
  } step_rec_t;

  // One result transaction.
  typedef struct packed {
    logic                   char_valid;
    logic [DICT_W-1:0]      char_index;
    logic [SCORE_W-1:0]     char_score;
    logic                   seq_done;
    logic [SCORE_W-1:0]     avg_score;
    logic [COUNT_OUT_W-1:0] char_count;
  } result_t;

endpackage

// File: hw/rtl/ctc_front.sv
// Front end: running argmax over the class scores of one timestep.
// Depends on ctc_pkg; produces one step_rec_t per finished timestep.
module ctc_front #(
  parameter int CLASS_COUNT = 8192
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic [ctc_pkg::SCORE_W-1:0]     class_score,
  input  logic                            last_class,
  input  logic                            last_step,
  output logic                            rec_push,
  output ctc_pkg::step_rec_t              rec
);

  localparam int CLS_W  = $clog2(CLASS_COUNT);
  localparam int DICT_W = ctc_pkg::DICT_W;
  localparam logic [CLS_W-1:0] CLS_LAST = CLS_W'(CLASS_COUNT - 1);

  logic [CLS_W-1:0]            class_counter;
  logic [ctc_pkg::SCORE_W-1:0] best_score;
  logic [CLS_W-1:0]            best_class;

  logic                        take_new;
  logic [ctc_pkg::SCORE_W-1:0] cand_score;
  logic [CLS_W-1:0]            cand_class;

  // The first class of a timestep always wins; later ones only on a strictly higher score.
  always_comb begin
    take_new   = (class_counter == '0) || (class_score > best_score);
    cand_score = take_new ? class_score   : best_score;
    cand_class = take_new ? class_counter : best_class;
  end

  // Reduce the winner to the dictionary width plus a flag for classes beyond it.
  always_comb begin
    rec.big       = (32'(cand_class) > ctc_pkg::CLASS_MAX);
    rec.cls       = DICT_W'(cand_class);
    rec.score     = cand_score;
    rec.last_step = last_step;
    rec_push      = accept && last_class;
  end

  // Running maximum and class counter; cleared at the end of each timestep.
  always_ff @(posedge clk) begin
    if (rst) begin
      class_counter <= '0;
      best_score    <= '0;
      best_class    <= '0;
    end else if (accept) begin
      if (last_class) begin
        class_counter <= '0;
        best_score    <= '0;
        best_class    <= '0;
      end else begin
        best_score <= cand_score;
        best_class <= cand_class;
        if (class_counter < CLS_LAST) begin
          class_counter <= class_counter + 1'b1;
        end
      end
    end
  end

endmodule

// File: hw/rtl/ctc_queue.sv
// Short queue of finished timesteps between the front and the back.
// Depends on ctc_pkg for the record type and the depth.
`include "assert_macros.svh"

module ctc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ctc_pkg::step_rec_t wr_rec,
  output logic               full,
  input  logic               pop,
  output ctc_pkg::step_rec_t rd_rec,
  output logic               empty
);

  localparam int DEPTH = ctc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = ctc_pkg::QUEUE_PTR_W;

  ctc_pkg::step_rec_t entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;

  logic do_push;
  logic do_pop;

  // Status and head of the queue.
  always_comb begin
    full    = (count == (PTR_W+1)'(DEPTH));
    empty   = (count == '0);
    do_push = push && !full;
    do_pop  = pop && !empty;
    rd_rec  = entries[rd_ptr];
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_rec;
    end
  end

  `ASSERT_NEVER(a_queue_overfill, clk, rst, count > (PTR_W+1)'(DEPTH), "queue fill level beyond its depth")
  `ASSERT_NEVER(a_queue_pop_empty, clk, rst, pop && empty, "record taken from an empty queue")
  `ASSERT_CLK(a_queue_push_held, clk, rst, (do_push && !do_pop) |=> !empty, "pushed record went missing")

endmodule

// File: hw/rtl/ctc_back.sv
// Back end: collapse and dictionary test, score sum and count, the mean
// at the end of a sequence by a bit-serial divider, and the result register.
// Depends on ctc_pkg.
`include "assert_macros.svh"

module ctc_back #(
  parameter int MAX_STEPS = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [ctc_pkg::DICT_W-1:0]  dict_size,
  input  ctc_pkg::step_rec_t          rec,
  input  logic                        rec_empty,
  output logic                        rec_pop,
  output ctc_pkg::result_t            result,
  output logic                        out_valid,
  input  logic                        pop
);

  localparam int CNT_W   = $clog2(MAX_STEPS + 1);
  localparam int SUM_W   = ctc_pkg::SUM_W;
  localparam int SCORE_W = ctc_pkg::SCORE_W;
  localparam int DICT_W  = ctc_pkg::DICT_W;
  localparam int COUT_W  = ctc_pkg::COUNT_OUT_W;
  localparam int DCNT_W  = ctc_pkg::DIV_CNT_W;
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_STEPS);
  localparam logic [DCNT_W-1:0] DIV_FIRST = DCNT_W'(SUM_W - 1);

  typedef enum logic [1:0] {
    ST_RUN = 2'b01,
    ST_DIV = 2'b10
  } back_state_t;

  back_state_t      state;
  logic [SUM_W-1:0] score_sum;
  logic [CNT_W-1:0] emit_count;
  logic [DICT_W-1:0] prev_cls;
  logic             prev_big;

  logic [SUM_W-1:0]  div_quo;
  logic [CNT_W-1:0]  div_rem;
  logic [CNT_W-1:0]  divisor;
  logic [DCNT_W-1:0] div_cnt;

  logic             take;
  logic             emit;
  logic [SUM_W:0]   sum_add;
  logic [SUM_W-1:0] sum_next;
  logic [CNT_W-1:0] count_next;
  logic             start_div;
  ctc_pkg::result_t res_now;

  logic [CNT_W:0]     trial;
  logic               ge;
  logic [CNT_W-1:0]   rem_step;
  logic [SUM_W-1:0]   quo_step;
  logic [SCORE_W-1:0] avg;

  // Take a timestep record when idle and the result register is free.
  always_comb begin
    take    = (state == ST_RUN) && !rec_empty && (!out_valid || pop);
    rec_pop = take;
  end

  // Emission test, saturating sum and count, and the result of this timestep.
  always_comb begin
    emit = !rec.big && (rec.cls != '0) && (rec.cls <= dict_size) &&
           (prev_big || (prev_cls != rec.cls));
    sum_add  = {1'b0, score_sum} + (SUM_W+1)'(rec.score);
    sum_next = score_sum;
    if (emit) begin
      sum_next = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
    end
    count_next = emit_count;
    if (emit && (emit_count < CNT_MAX)) begin
      count_next = emit_count + 1'b1;
    end
    start_div = take && rec.last_step && (count_next != '0);

    res_now.char_valid = emit;
    res_now.char_index = emit ? (rec.cls - 1'b1) : '0;
    res_now.char_score = rec.score;
    res_now.seq_done   = rec.last_step;
    res_now.avg_score  = '0;
    res_now.char_count = COUT_W'(count_next);
  end

  // One restoring division step; the quotient is capped to the score width.
  always_comb begin
    trial    = {div_rem, div_quo[SUM_W-1]};
    ge       = (trial >= {1'b0, divisor});
    rem_step = ge ? CNT_W'(trial - {1'b0, divisor}) : CNT_W'(trial);
    quo_step = {div_quo[SUM_W-2:0], ge};
    avg      = (|quo_step[SUM_W-1:SCORE_W]) ? '1 : quo_step[SCORE_W-1:0];
  end

  // Control state and the per-sequence accumulators.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_RUN;
      out_valid  <= 1'b0;
      score_sum  <= '0;
      emit_count <= '0;
      prev_cls   <= '0;
      prev_big   <= 1'b0;
    end else begin
      case (state)
        ST_RUN: begin
          if (take) begin
            if (rec.last_step) begin
              score_sum  <= '0;
              emit_count <= '0;
              prev_cls   <= '0;
              prev_big   <= 1'b0;
            end else begin
              score_sum  <= sum_next;
              emit_count <= count_next;
              prev_cls   <= rec.cls;
              prev_big   <= rec.big;
            end
            if (start_div) begin
              state     <= ST_DIV;
              out_valid <= 1'b0;
            end else begin
              out_valid <= 1'b1;
            end
          end else if (pop) begin
            out_valid <= 1'b0;
          end
        end
        ST_DIV: begin
          if (div_cnt == '0) begin
            state     <= ST_RUN;
            out_valid <= 1'b1;
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

  // Result register and divider datapath.
  always_ff @(posedge clk) begin
    if (take) begin
      result  <= res_now;
      div_quo <= sum_next;
      div_rem <= '0;
      divisor <= count_next;
      div_cnt <= DIV_FIRST;
    end else if (state == ST_DIV) begin
      div_quo <= quo_step;
      div_rem <= rem_step;
      div_cnt <= div_cnt - 1'b1;
      if (div_cnt == '0) begin
        result.avg_score <= avg;
      end
    end
  end

  `ASSERT_NEVER(a_back_div_busy, clk, rst, (state == ST_DIV) && out_valid,
                "result shown while the mean is still being divided")
  `ASSERT_CLK(a_back_seq_clear, clk, rst, (take && rec.last_step) |=> (emit_count == '0),
              "sequence count not cleared after its last timestep")
  `ASSERT_NEVER(a_back_avg_mid, clk, rst,
                out_valid && !result.seq_done && (result.avg_score != '0),
                "mean given on a timestep inside a sequence")
  `ASSERT_CLK(a_back_index, clk, rst,
              (out_valid && result.char_valid) |-> (result.char_index < dict_size),
              "emitted character outside the dictionary")

endmodule

// File: hw/rtl/ctc_greedy_decoder.sv
// Greedy CTC decoder, top level.
// Depends on ctc_pkg, ctc_front, ctc_queue and ctc_back.
//
// Usage:
//   Class scores enter one per transaction on the push/full side, one
//   timestep after another; last_class marks the final score of a timestep
//   and last_step, on that same transaction, ends the sequence.
//   Each timestep gives one result transaction on the empty/pop side: the emitted
//   character (if any), the winning score, and, on the transaction that ends a
//   sequence, the mean score of emitted characters. dict_size must be written
//   via cfg_we/cfg_data while the block is idle; the block does not enforce it.
// Timing:
//   One class score is taken per cycle while full is low. A timestep's
//   result passes through the queue and then the result register to the
//   result ports. The last timestep of a sequence with at least one
//   character is held in the back end while the one-bit-per-cycle divider
//   works through the 26-bit score sum; up to four finished timesteps queue
//   meanwhile, so the input stalls only when that queue is full.
// Reset:
//   rst clears all sequence state and the queue, and sets dict_size to 8191.
//   When pop is held low the result register holds its transaction, the
//   queue fills, and full then stalls the input.
module ctc_greedy_decoder #(
  parameter int CLASS_COUNT = 8192,
  parameter int MAX_STEPS   = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic [ctc_pkg::SCORE_W-1:0]        class_score,
  input  logic                               last_class,
  input  logic                               last_step,
  input  logic                               cfg_we,
  input  logic [ctc_pkg::DICT_W-1:0]         cfg_data,
  output logic                               empty,
  input  logic                               pop,
  output logic                               char_valid,
  output logic [ctc_pkg::DICT_W-1:0]         char_index,
  output logic [ctc_pkg::SCORE_W-1:0]        char_score,
  output logic                               seq_done,
  output logic [ctc_pkg::SCORE_W-1:0]        avg_score,
  output logic [ctc_pkg::COUNT_OUT_W-1:0]    char_count
);

  logic [ctc_pkg::DICT_W-1:0] dict_size;
  logic                       accept;
  logic                       rec_push;
  ctc_pkg::step_rec_t         wr_rec;
  ctc_pkg::step_rec_t         rd_rec;
  logic                       rec_empty;
  logic                       rec_pop;
  ctc_pkg::result_t           result;
  logic                       out_valid;

  // Dictionary size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      dict_size <= ctc_pkg::DICT_RESET;
    end else if (cfg_we) begin
      dict_size <= cfg_data;
    end
  end

  assign accept = push && !full;

  ctc_front #(
    .CLASS_COUNT(CLASS_COUNT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .class_score(class_score),
    .last_class (last_class),
    .last_step  (last_step),
    .rec_push   (rec_push),
    .rec        (wr_rec)
  );

  ctc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (rec_push),
    .wr_rec(wr_rec),
    .full  (full),
    .pop   (rec_pop),
    .rd_rec(rd_rec),
    .empty (rec_empty)
  );

  ctc_back #(
    .MAX_STEPS(MAX_STEPS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .dict_size(dict_size),
    .rec      (rd_rec),
    .rec_empty(rec_empty),
    .rec_pop  (rec_pop),
    .result   (result),
    .out_valid(out_valid),
    .pop      (pop)
  );

  // Result ports.
  always_comb begin
    empty      = !out_valid;
    char_valid = result.char_valid;
    char_index = result.char_index;
    char_score = result.char_score;
    seq_done   = result.seq_done;
    avg_score  = result.avg_score;
    char_count = result.char_count;
  end

endmodule
